// File: sv/vhse_pkg.sv
// vhse_pkg: shared types and constants of the VBR header seek engine.
// Used by vhse_front, vhse_back and vbr_header_seek_engine. No dependencies.

package vhse_pkg;

	localparam int TOC_ENTRIES = 100;
	localparam int TOC_AW      = $clog2(TOC_ENTRIES);
	localparam logic [TOC_AW-1:0] TOC_LAST = TOC_AW'(TOC_ENTRIES - 1);

	localparam logic [14:0] PCT_FULL = 15'd25600;

	localparam logic [31:0] TAG_XING = 32'h5869_6E67;
	localparam logic [31:0] TAG_INFO = 32'h496E_666F;

	localparam int FLAG_FRAMES = 0;
	localparam int FLAG_BYTES  = 1;
	localparam int FLAG_TOC    = 2;
	localparam int FLAG_SCALE  = 3;

	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_SEEK   = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ID3      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 1'b1;

	// floor(v / 100) = (v * DIV_RECIP) >> DIV_SHIFT for v < 25600
	localparam logic [12:0] DIV_RECIP = 13'd5243;
	localparam int DIV_SHIFT = 19;
	localparam logic [6:0] DIV_BASE = 7'd100;

	typedef struct packed {
		logic              is_seek;
		logic              restart;
		logic [7:0]        data;
		logic [14:0]       pct;
		logic [TOC_AW-1:0] toc_idx;
		logic [8:0]        frac;
	} vhse_word_t;

endpackage

// File: sv/vbr_header_seek_engine.sv
// vbr_header_seek_engine: Xing/Info VBR header parser with TOC seek lookup.
// Holds the configuration registers and joins vhse_front and vhse_back.
// Depends on vhse_pkg, vhse_front, vhse_back, vhse_ram.
//
// Input words carry either one header byte (req_type 0) or a seek query
// (req_type 1); every word yields exactly one result word, in order.
// first_byte restarts the parse at the tag. Header words update the
// parse state and return it; seek words return the file offset plus the
// ID3 length. id3_length (index 0) and fallback_length (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// word is in flight, as the block does not enforce it. A two-word input
// queue decouples acceptance from execution. A header byte's result is
// registered when the back end pops the byte. A TOC seek steps through
// RD_LO, RD_HI, MUL and OUT (two TOC RAM reads, interpolate, multiply); a
// linear seek through LMUL, five radix-256 DIV steps dividing by 100, and
// OUT. The back end sequencer runs one word at a time and pops no word
// before the last result is loaded. Reset clears the parse state, the queue
// and the output valid flag; TOC contents are undefined until a header
// writes them. When out_stall is high the result holds, the back end holds
// its next result, and the queue fills before in_stall rises.

module vbr_header_seek_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [7:0]                     data_byte,
	input  logic                           first_byte,
	input  logic [14:0]                    seek_percent,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [32:0]                    seek_offset,
	output logic                           header_valid,
	output logic [31:0]                    frame_count,
	output logic                           parse_done,
	input  logic                           cfg_we,
	input  logic [vhse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	import vhse_pkg::*;

	logic [28:0] id3_q;
	logic [31:0] fallback_q;
	logic        head_valid;
	logic        pop;
	vhse_word_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id3_q      <= '0;
			fallback_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ID3:      id3_q      <= cfg_data[28:0];
				CFG_FALLBACK: fallback_q <= cfg_data;
				default: ;
			endcase
		end
	end

	vhse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.seek_percent (seek_percent),
		.pop          (pop),
		.head_valid   (head_valid),
		.head         (head)
	);

	vhse_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.id3_length      (id3_q),
		.fallback_length (fallback_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.seek_offset     (seek_offset),
		.header_valid    (header_valid),
		.frame_count     (frame_count),
		.parse_done      (parse_done)
	);

endmodule

// File: sv/vhse_ram.sv
// vhse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module vhse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/vhse_front.sv
// vhse_front: input side; classifies each word and queues it for the back end.
// Depends on vhse_pkg.

module vhse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic [14:0]          seek_percent,
	input  logic                 pop,
	output logic                 head_valid,
	output vhse_pkg::vhse_word_t head
);

	import vhse_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	vhse_word_t        mem_q [QDEPTH];
	logic [QPW-1:0]    wr_ptr_q;
	logic [QPW-1:0]    rd_ptr_q;
	logic [QCW-1:0]    cnt_q;
	logic              push;
	vhse_word_t        word;
	logic [14:0]       pct;
	logic [TOC_AW-1:0] seg;
	logic [14:0]       frac_w;

	always_comb begin
		pct = (seek_percent > PCT_FULL) ? PCT_FULL : seek_percent;
		seg = pct[14:8];
		if (seg > TOC_LAST) begin
			seg = TOC_LAST;
		end
		frac_w = pct - {seg, 8'd0};
		word.is_seek = (req_type == REQ_SEEK);
		word.restart = first_byte;
		word.data    = data_byte;
		word.pct     = pct;
		word.toc_idx = seg;
		word.frac    = frac_w[8:0];
	end

	assign in_stall   = (cnt_q == QCW'(QDEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("queue count out of range");

endmodule

// File: sv/vhse_back.sv
// vhse_back: header parser, TOC store, seek sequencer and output register.
// Depends on vhse_pkg and vhse_ram.

module vhse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  vhse_pkg::vhse_word_t head,
	output logic                 pop,
	input  logic [28:0]          id3_length,
	input  logic [31:0]          fallback_length,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [32:0]          seek_offset,
	output logic                 header_valid,
	output logic [31:0]          frame_count,
	output logic                 parse_done
);

	import vhse_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD_LO = 3'd1;
	localparam logic [2:0] ST_RD_HI = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_LMUL  = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	localparam logic [6:0] HDR_LEN  = 7'd8;
	localparam logic [6:0] WORD_LEN = 7'd4;
	localparam logic [2:0] DIV_STEPS = 3'd4;

	function automatic logic [6:0] end_of(input logic [3:0] fl);
		logic [6:0] p;
		p = HDR_LEN;
		p = p + (fl[FLAG_FRAMES] ? WORD_LEN : 7'd0);
		p = p + (fl[FLAG_BYTES] ? WORD_LEN : 7'd0);
		p = p + (fl[FLAG_TOC] ? 7'(TOC_ENTRIES) : 7'd0);
		p = p + (fl[FLAG_SCALE] ? WORD_LEN : 7'd0);
		return p;
	endfunction

	logic [2:0]  state_q;
	logic        out_free;
	logic        hdr_take;

	// parser state
	logic [6:0]  idx_q;
	logic [3:0]  flags_q;
	logic [31:0] ws_q;
	logic [31:0] frames_q;
	logic [31:0] bytes_q;
	logic        valid_q;
	logic        tocp_q;
	logic        fin_q;

	logic [6:0]  idx_e, idx_n;
	logic [3:0]  flags_e, flags_n, fl_use;
	logic [31:0] ws_e, ws_n, ws_sh;
	logic [31:0] frames_e, frames_n;
	logic [31:0] bytes_e, bytes_n;
	logic        valid_e, valid_n;
	logic        tocp_e, tocp_n;
	logic        fin_e, fin_n;
	logic        stop;
	logic [6:0]  bpos, tpos, spos;
	logic [7:0]  idx_inc;
	logic        toc_we;
	logic [6:0]  toc_k;

	// seek datapath
	logic [TOC_AW-1:0] seg_q;
	logic [8:0]        frac_q;
	logic [14:0]       pct_q;
	logic [31:0]       len_q;
	logic [TOC_AW-1:0] raddr;
	logic [7:0]        rdata;
	logic [7:0]        lo_q;
	logic [8:0]        hi;
	logic signed [9:0]  diff;
	logic signed [19:0] dprod;
	logic signed [20:0] xs;
	logic [16:0]       x_q;
	logic [48:0]       xprod;
	logic [46:0]       lprod;
	logic [39:0]       div_q;
	logic [6:0]        rem_q;
	logic [31:0]       quo_q;
	logic [2:0]        dcnt_q;
	logic [14:0]       dv;
	logic [27:0]       dq_full;
	logic [7:0]        dq;
	logic [14:0]       dr;
	logic [32:0]       off_q;

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == ST_IDLE) && head_valid && (head.is_seek || out_free);
	assign hdr_take = pop && !head.is_seek;

	always_comb begin
		idx_e    = head.restart ? 7'd0  : idx_q;
		flags_e  = head.restart ? 4'd0  : flags_q;
		ws_e     = head.restart ? 32'd0 : ws_q;
		frames_e = head.restart ? 32'd0 : frames_q;
		bytes_e  = head.restart ? 32'd0 : bytes_q;
		valid_e  = head.restart ? 1'b0  : valid_q;
		tocp_e   = head.restart ? 1'b0  : tocp_q;
		fin_e    = head.restart ? 1'b0  : fin_q;

		ws_sh = {ws_e[23:0], head.data};
		bpos  = HDR_LEN + (flags_e[FLAG_FRAMES] ? WORD_LEN : 7'd0);
		tpos  = bpos + (flags_e[FLAG_BYTES] ? WORD_LEN : 7'd0);
		spos  = tpos + (flags_e[FLAG_TOC] ? 7'(TOC_ENTRIES) : 7'd0);
		toc_k = idx_e - tpos;
		idx_inc = {1'b0, idx_e} + 8'd1;

		idx_n    = idx_e;
		flags_n  = flags_e;
		ws_n     = ws_e;
		frames_n = frames_e;
		bytes_n  = bytes_e;
		valid_n  = valid_e;
		tocp_n   = tocp_e;
		fin_n    = fin_e;
		fl_use   = flags_e;
		stop     = 1'b0;
		toc_we   = 1'b0;

		if (!fin_e) begin
			ws_n = ws_sh;
			if (idx_e < HDR_LEN) begin
				if (idx_e == 7'd3 && ws_sh != TAG_XING && ws_sh != TAG_INFO) begin
					fin_n = 1'b1;
					stop  = 1'b1;
				end
				if (idx_e == 7'd7) begin
					flags_n = ws_sh[3:0];
					fl_use  = ws_sh[3:0];
					tocp_n  = ws_sh[FLAG_TOC];
					if (!ws_sh[FLAG_FRAMES]) begin
						fin_n = 1'b1;
						stop  = 1'b1;
					end
				end
			end else if (idx_e < bpos) begin
				if (idx_e == bpos - 7'd1) begin
					frames_n = ws_sh;
					if (ws_sh == 32'd0) begin
						fin_n = 1'b1;
						stop  = 1'b1;
					end
				end
			end else if (idx_e < tpos) begin
				if (idx_e == tpos - 7'd1) begin
					bytes_n = ws_sh;
				end
			end else if (idx_e < spos) begin
				toc_we = hdr_take;
			end
			if (!stop) begin
				idx_n = idx_inc[6:0];
				if (idx_inc >= {1'b0, HDR_LEN} && idx_inc >= {1'b0, end_of(fl_use)}) begin
					valid_n = 1'b1;
					fin_n   = 1'b1;
				end
			end
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:  raddr = head.toc_idx;
			ST_RD_LO: raddr = (seg_q == TOC_LAST) ? seg_q : seg_q + 1'b1;
			default:  raddr = seg_q;
		endcase
	end

	vhse_ram #(
		.WIDTH(8),
		.DEPTH(TOC_ENTRIES)
	) u_toc (
		.clk   (clk),
		.we    (toc_we),
		.waddr (toc_k[TOC_AW-1:0]),
		.wdata (head.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		hi    = (seg_q == TOC_LAST) ? 9'd256 : {1'b0, rdata};
		diff  = $signed({1'b0, hi}) - $signed({2'b0, lo_q});
		dprod = diff * $signed({1'b0, frac_q});
		xs    = $signed({5'd0, lo_q, 8'd0}) + $signed({dprod[19], dprod});
		xprod = x_q * bytes_q;
		lprod = len_q * pct_q;
		dv      = {rem_q, div_q[39:32]};
		dq_full = dv * DIV_RECIP;
		dq      = dq_full[DIV_SHIFT+7:DIV_SHIFT];
		dr      = dv - dq * DIV_BASE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			idx_q     <= '0;
			flags_q   <= '0;
			ws_q      <= '0;
			frames_q  <= '0;
			bytes_q   <= '0;
			valid_q   <= 1'b0;
			tocp_q    <= 1'b0;
			fin_q     <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			if (hdr_take || (state_q == ST_OUT && out_free)) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (hdr_take) begin
				idx_q     <= idx_n;
				flags_q   <= flags_n;
				ws_q      <= ws_n;
				frames_q  <= frames_n;
				bytes_q   <= bytes_n;
				valid_q   <= valid_n;
				tocp_q    <= tocp_n;
				fin_q     <= fin_n;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.is_seek) begin
						state_q <= (valid_q && tocp_q) ? ST_RD_LO : ST_LMUL;
					end
				end
				ST_RD_LO: state_q <= ST_RD_HI;
				ST_RD_HI: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_OUT;
				ST_LMUL: begin
					dcnt_q  <= DIV_STEPS;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_seek) begin
			seg_q  <= head.toc_idx;
			frac_q <= head.frac;
			pct_q  <= head.pct;
			len_q  <= valid_q ? bytes_q : fallback_length;
			rem_q  <= '0;
		end
		if (state_q == ST_RD_LO) begin
			lo_q <= rdata;
		end
		if (state_q == ST_RD_HI) begin
			x_q <= xs[16:0];
		end
		if (state_q == ST_MUL) begin
			off_q <= xprod[48:16];
		end
		if (state_q == ST_LMUL) begin
			div_q <= {1'b0, lprod[46:8]};
		end
		if (state_q == ST_DIV) begin
			div_q <= {div_q[31:0], 8'd0};
			rem_q <= dr[6:0];
			quo_q <= {quo_q[23:0], dq};
			off_q <= {1'b0, quo_q[23:0], dq};
		end
		if (hdr_take) begin
			seek_offset  <= '0;
			header_valid <= valid_n;
			frame_count  <= frames_n;
			parse_done   <= fin_n;
		end else if (state_q == ST_OUT && out_free) begin
			seek_offset  <= off_q + {4'd0, id3_length};
			header_valid <= valid_q;
			frame_count  <= frames_q;
			parse_done   <= fin_q;
		end
	end

	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> fin_q)
		else $error("header valid without finished parse");

	a_toc_flag: assert property (@(posedge clk) disable iff (!arst_n)
		tocp_q |-> flags_q[FLAG_TOC])
		else $error("toc present without toc flag");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_free |=> out_valid && (state_q == ST_IDLE))
		else $error("seek result not delivered");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid && (state_q == ST_IDLE))
		else $error("pop from empty queue or while busy");

endmodule

// File: test/vbr_header_seek_engine_test.sv
// Self-checking testbench for vbr_header_seek_engine: VBR header words and seek words
// are checked against an in-bench model of the parser and the TOC/linear seek math.
// Depends on vhse_pkg and the vbr_header_seek_engine RTL.
`timescale 1ns / 100ps

module vbr_header_seek_engine_test;
	import vhse_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_WORDS  = 550;
	localparam int HEADER_SLACK  = 60;
	localparam int TOC_TOP       = TOC_ENTRIES - 1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  hdr_byte;
		logic        first;
		logic [14:0] pct;
	} engine_word_t;

	typedef struct packed {
		logic [32:0] offset;
		logic        valid;
		logic [31:0] frames;
		logic        done;
	} engine_result_t;

	typedef struct {
		engine_word_t   word;
		bit             typed;
		engine_result_t result;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 req_type = 1'b0;
	logic [7:0]           data_byte = '0;
	logic                 first_byte = 1'b0;
	logic [14:0]          seek_percent = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [32:0]          seek_offset;
	logic                 header_valid;
	logic [31:0]          frame_count;
	logic                 parse_done;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	vbr_header_seek_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.seek_percent(seek_percent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.seek_offset(seek_offset),
		.header_valid(header_valid),
		.frame_count(frame_count),
		.parse_done(parse_done),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// parser and seek model state
	logic [6:0]  hdr_pos;
	logic [3:0]  hdr_flags;
	logic [31:0] hdr_shift;
	logic [31:0] hdr_frames;
	logic [31:0] hdr_bytes;
	logic [7:0]  toc_mem [TOC_ENTRIES];
	logic        hdr_valid;
	logic        hdr_has_toc;
	logic        hdr_done;
	logic [28:0] cfg_id3 = '0;
	logic [31:0] cfg_fallback = '0;

	engine_result_t results_due[$];
	stim_row_t      directed_rows[$];
	logic [7:0]     header_image[$];

	int mismatches  = 0;
	int words_sent  = 0;
	int cycle_count = 0;
	int burst_left  = 0;
	int gap_max     = 0;
	int stall_max   = 0;
	int stall_run   = 0;
	bit stall_on    = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** vbr_header_seek_engine: FAILED **");
			$finish;
		end
	end

	function automatic void clear_parse();
		hdr_pos = '0;
		hdr_flags = '0;
		hdr_shift = '0;
		hdr_frames = '0;
		hdr_bytes = '0;
		hdr_valid = 1'b0;
		hdr_has_toc = 1'b0;
		hdr_done = 1'b0;
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		int unsigned pos, bpos, tpos, spos, stop;
		pos = hdr_pos;
		bpos = 8 + (hdr_flags[FLAG_FRAMES] ? 4 : 0);
		tpos = bpos + (hdr_flags[FLAG_BYTES] ? 4 : 0);
		spos = tpos + (hdr_flags[FLAG_TOC] ? TOC_ENTRIES : 0);
		stop = spos + (hdr_flags[FLAG_SCALE] ? 4 : 0);
		hdr_shift = {hdr_shift[23:0], b};
		if (pos < 8) begin
			if (pos == 3 && hdr_shift != TAG_XING && hdr_shift != TAG_INFO) begin
				hdr_done = 1'b1;
				return;
			end
			if (pos == 7) begin
				hdr_flags = hdr_shift[3:0];
				hdr_has_toc = hdr_flags[FLAG_TOC];
				if (!hdr_flags[FLAG_FRAMES]) begin
					hdr_done = 1'b1;
					return;
				end
				bpos = 12;
				tpos = bpos + (hdr_flags[FLAG_BYTES] ? 4 : 0);
				spos = tpos + (hdr_flags[FLAG_TOC] ? TOC_ENTRIES : 0);
				stop = spos + (hdr_flags[FLAG_SCALE] ? 4 : 0);
			end
		end else if (pos < bpos) begin
			if (pos == bpos - 1) begin
				hdr_frames = hdr_shift;
				if (hdr_frames == 0) begin
					hdr_done = 1'b1;
					return;
				end
			end
		end else if (pos < tpos) begin
			if (pos == tpos - 1)
				hdr_bytes = hdr_shift;
		end else if (pos < spos) begin
			toc_mem[pos - tpos] = b;
		end
		pos++;
		hdr_pos = 7'(pos);
		if (pos >= 8 && pos >= stop) begin
			hdr_valid = 1'b1;
			hdr_done = 1'b1;
		end
	endfunction

	function automatic logic [32:0] seek_position(logic [14:0] pct);
		longint unsigned p, seg, off;
		longint lo, hi, frac, x;
		p = (pct > PCT_FULL) ? PCT_FULL : pct;
		if (hdr_valid && hdr_has_toc) begin
			seg = p >> 8;
			if (seg > TOC_TOP)
				seg = TOC_TOP;
			frac = longint'(p) - longint'(seg) * 256;
			lo = toc_mem[seg];
			hi = (seg < TOC_TOP) ? longint'(toc_mem[seg + 1]) : 256;
			x = lo * 256 + (hi - lo) * frac;
			off = (unsigned'(x) * hdr_bytes) >> 16;
		end else begin
			off = ((hdr_valid ? hdr_bytes : cfg_fallback) * p) / PCT_FULL;
		end
		return 33'(off + cfg_id3);
	endfunction

	function automatic engine_result_t engine_step(engine_word_t w);
		logic [32:0] off;
		off = '0;
		if (w.kind == REQ_HEADER) begin
			if (w.first)
				clear_parse();
			if (!hdr_done)
				parse_byte(w.hdr_byte);
		end else begin
			off = seek_position(w.pct);
		end
		return {off, hdr_valid, hdr_frames, hdr_done};
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		engine_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {seek_offset, header_valid, frame_count, parse_done};
			if (results_due.size() == 0) begin
				note_mismatch($sformatf("unexpected word off=%0d valid=%0b frames=%0d done=%0b",
					got.offset, got.valid, got.frames, got.done));
			end else begin
				want = results_due.pop_front();
				if (got.offset !== want.offset || got.valid !== want.valid ||
						got.frames !== want.frames || got.done !== want.done)
					note_mismatch($sformatf(
						"exp off=%0d valid=%0b frames=%0d done=%0b, got off=%0d valid=%0b frames=%0d done=%0b",
						want.offset, want.valid, want.frames, want.done,
						got.offset, got.valid, got.frames, got.done));
			end
		end
	end

	// receiver: alternating runs of stall and flow
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_on = !stall_on;
			stall_run = stall_on ? $urandom_range(1, stall_max + 1) : $urandom_range(1, 20);
		end
		stall_run--;
		out_stall <= stall_on && (stall_max != 0);
	end

	task automatic send_word(input engine_word_t w, input bit typed, input engine_result_t fixed);
		int gap;
		engine_result_t predicted;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max != 0)
				gap = $urandom_range(1, gap_max);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= w.kind;
		data_byte <= w.hdr_byte;
		first_byte <= w.first;
		seek_percent <= w.pct;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = engine_step(w);
		results_due.push_back(typed ? fixed : predicted);
		words_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ID3)
			cfg_id3 = value[28:0];
		else
			cfg_fallback = value;
	endtask

	task automatic add_row(input logic kind, input logic [7:0] b, input logic fb,
			input logic [14:0] pct, input bit typed, input engine_result_t r);
		stim_row_t row;
		row.word = {kind, b, fb, pct};
		row.typed = typed;
		row.result = r;
		directed_rows.push_back(row);
	endtask

	function automatic logic [14:0] pick_pct();
		case ($urandom_range(0, 9))
			0: case ($urandom_range(0, 6))
				0: return 15'd0;
				1: return 15'd255;
				2: return 15'd256;
				3: return 15'd25343;
				4: return 15'd25344;
				5: return 15'd25599;
				default: return PCT_FULL;
			endcase
			1: return 15'($urandom_range(25601, 32767));
			2: return 15'($urandom);
			default: return 15'($urandom_range(0, 25600));
		endcase
	endfunction

	task automatic send_seek(input logic [14:0] pct);
		engine_word_t w;
		w = {REQ_SEEK, 8'($urandom), 1'($urandom), pct};
		send_word(w, 1'b0, '0);
	endtask

	task automatic send_header_byte(input logic [7:0] b, input logic fb);
		engine_word_t w;
		w = {REQ_HEADER, b, fb, 15'($urandom)};
		send_word(w, 1'b0, '0);
	endtask

	function automatic void append_word(logic [31:0] v);
		for (int k = 3; k >= 0; k--)
			header_image.push_back(v[8*k +: 8]);
	endfunction

	// mostly well-formed headers; some with a damaged tag, cut short or restarted
	task automatic send_header();
		logic [31:0] tag, flag_word, frames, length;
		bit broken;
		int level, cut;
		header_image.delete();
		broken = ($urandom_range(0, 4) == 0);
		tag = $urandom_range(0, 1) ? TAG_XING : TAG_INFO;
		if (broken && $urandom_range(0, 2) == 0)
			tag[$urandom_range(0, 31)] ^= 1'b1;
		flag_word = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
		if ($urandom_range(0, 5) != 0)
			flag_word[FLAG_FRAMES] = 1'b1;
		case ($urandom_range(0, 7))
			0: frames = '0;
			1: frames = 32'd1;
			2: frames = '1;
			default: frames = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0: length = '0;
			1: length = '1;
			default: length = $urandom;
		endcase
		append_word(tag);
		append_word(flag_word);
		if (flag_word[FLAG_FRAMES])
			append_word(frames);
		if (flag_word[FLAG_BYTES])
			append_word(length);
		if (flag_word[FLAG_TOC]) begin
			level = 0;
			for (int k = 0; k < TOC_ENTRIES; k++) begin
				if ($urandom_range(0, 3) == 0)
					header_image.push_back(8'($urandom));
				else
					header_image.push_back(level > 255 ? 8'hFF : 8'(level));
				level += $urandom_range(0, 6);
			end
		end
		if (flag_word[FLAG_SCALE])
			append_word($urandom);
		cut = broken ? $urandom_range(1, header_image.size()) : header_image.size();
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_seek(pick_pct());
			send_header_byte(header_image[i], i == 0 || (broken && $urandom_range(0, 29) == 0));
		end
		repeat ($urandom_range(0, 2))
			send_header_byte(8'($urandom), 1'b0);
		repeat ($urandom_range(1, (hdr_valid && hdr_has_toc) ? 24 : 5))
			send_seek(pick_pct());
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 1))
				send_seek(pick_pct());
			else
				send_header_byte(8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		int phase_end;
		clear_parse();
		foreach (toc_mem[k])
			toc_mem[k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_ID3, {3'b000, 29'h1FFF_FFFF});
		write_reg(CFG_FALLBACK, 32'hFFFF_FFFF);
		gap_max = 3;
		stall_max = 4;

		// seeks with no header held: linear over the fallback length, saturating
		add_row(REQ_SEEK, 8'h00, 1'b0, 15'd0, 1'b1, {33'h0_1FFF_FFFF, 1'b0, 32'd0, 1'b0});
		add_row(REQ_SEEK, 8'h00, 1'b0, 15'h7FFF, 1'b1, {33'h1_1FFF_FFFE, 1'b0, 32'd0, 1'b0});
		// bad tag, then a byte after the parse is done
		add_row(REQ_HEADER, "X", 1'b1, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "i", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "n", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "h", 1'b0, 15'd0, 1'b1, {33'd0, 1'b0, 32'd0, 1'b1});
		add_row(REQ_HEADER, "I", 1'b0, 15'd0, 1'b1, {33'd0, 1'b0, 32'd0, 1'b1});
		// no frame count flag
		add_row(REQ_HEADER, "I", 1'b1, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "n", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "f", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "o", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b1, {33'd0, 1'b0, 32'd0, 1'b1});
		// frames only: valid header with no byte length
		add_row(REQ_HEADER, "X", 1'b1, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "i", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "n", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, "g", 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h01, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h00, 1'b0, 15'd0, 1'b0, '0);
		add_row(REQ_HEADER, 8'h2A, 1'b0, 15'd0, 1'b1, {33'd0, 1'b1, 32'd42, 1'b1});
		add_row(REQ_SEEK, 8'h00, 1'b0, 15'd12800, 1'b1, {33'h0_1FFF_FFFF, 1'b1, 32'd42, 1'b1});
		add_row(REQ_SEEK, 8'hFF, 1'b1, PCT_FULL, 1'b0, '0);
		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					write_reg(CFG_ID3, '0);
					write_reg(CFG_FALLBACK, '0);
					gap_max = 0;
					stall_max = 0;
				end
				1: begin
					write_reg(CFG_ID3, {3'b000, 29'h1FFF_FFFF});
					write_reg(CFG_FALLBACK, 32'hFFFF_FFFF);
					gap_max = 4;
					stall_max = 3;
				end
				2: begin
					write_reg(CFG_ID3, {3'b000, 29'($urandom)});
					write_reg(CFG_FALLBACK, $urandom);
					gap_max = 9;
					stall_max = 12;
				end
				default: begin
					write_reg(CFG_ID3, $urandom_range(0, 4096));
					write_reg(CFG_FALLBACK, $urandom);
					gap_max = 2;
					stall_max = 5;
				end
			endcase
			// the last header of a phase runs past the mark
			phase_end = words_sent + RANDOM_WORDS / 4 - HEADER_SLACK;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					send_header();
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("** vbr_header_seek_engine: PASSED **");
		else
			$display("** vbr_header_seek_engine: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
sv/vhse_pkg.sv
sv/vhse_ram.sv
sv/vhse_front.sv
sv/vhse_back.sv
sv/vbr_header_seek_engine.sv
test/vbr_header_seek_engine_test.sv
